/* sv/xcr_pkg.sv */
// ============================================================================
// xcr_pkg
// Shared types and constants for the XMODEM checksum packet receiver.
// ============================================================================
`default_nettype none

package xcr_pkg;

    // Width of one byte in the data path.
    localparam int BYTE_W = 8;

    // Packet geometry: 128 data bytes behind SOH, block and complement.
    localparam int PKT_LEN  = 128;
    localparam int PKT_IW   = 7;
    localparam int FULL_LEN = PKT_LEN + 4;

    // Protocol bytes.
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_ACK = 8'h06;
    localparam logic [7:0] BYTE_NAK = 8'h15;
    localparam logic [7:0] BYTE_ERASED = 8'hFF;
    localparam logic [7:0] BLOCK_CHECK = 8'hFF;

    // Saturation limit of the byte counters.
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    // Command modes.
    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_PROMPT = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_FILL   = 2'd3;

    // Configuration register indexes.
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_LEAD_SKIP = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_NAK      = 3'd1,
        ST_EOT      = 3'd2,
        ST_UNREC    = 3'd3,
        ST_PROMPT   = 3'd4,
        ST_READBACK = 3'd5
    } status_t;

    // Kind of the buffer being assembled.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SOH   = 2'd1,
        KIND_EOT   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COPY,
        S_FILL
    } state_t;

endpackage : xcr_pkg

`default_nettype wire

/* sv/xcr_ram.sv */
// ============================================================================
// xcr_ram
// Byte-wide synchronous RAM with one write port and one registered read port.
// ============================================================================
`default_nettype none

module xcr_ram
    import xcr_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule : xcr_ram

`default_nettype wire

/* sv/xmodem_checksum_packet_receiver.sv */
// ============================================================================
// xmodem_checksum_packet_receiver
// XMODEM receiver for 128-byte packets with a one-byte additive checksum.
// ============================================================================
// Received bytes are taken while idle; a reply that needs no copy strobes done
// in the cycle after the last byte. A good SOH packet strobes done once the
// 128-entry staging-to-store copy loop has finished. A readback delivers its
// word through the registered store read and then the result registers.
// A refill writes min(capacity_bytes, STORE_DEPTH) store bytes from address 0,
// one store write per cycle. After reset the whole store is swept to 0xFF.
// ============================================================================
`default_nettype none

module xmodem_checksum_packet_receiver
    import xcr_pkg::*;
#(
    parameter int STORE_DEPTH = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        last_of_buffer,
    input  wire logic [13:0] read_addr,
    input  wire logic        wr_en,
    input  wire logic        wr_index,
    input  wire logic [14:0] wr_data,
    output logic             done,
    output logic [2:0]       status,
    output logic             reply_valid,
    output logic [7:0]       reply_byte,
    output logic [7:0]       read_data,
    output logic [23:0]      session_bytes
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int WAW = AW + 1;
    localparam int CAW = AW + 2;
    localparam int LW  = (AW + 1 > 15) ? AW + 1 : 15;
    localparam int RW  = (AW > 14) ? AW + 1 : 15;

    // Configuration registers.
    logic [14:0] cap_reg;
    logic        lead_skip_reg;

    // Sequencer and counters.
    state_t         state_reg, state_next;
    logic [LW-1:0]  sweep_reg, sweep_next;
    logic [7:0]     copy_cnt_reg, copy_cnt_next;
    logic           in_range_reg, in_range_next;

    // Session state.
    logic [WAW-1:0] write_addr_reg, write_addr_next;
    logic [23:0]    rx_count_reg, rx_count_next;
    logic [23:0]    session_reg, session_next;

    // Packet assembly state.
    logic [7:0]     byte_pos_reg, byte_pos_next;
    kind_t          kind_reg, kind_next;
    logic [7:0]     block_reg, block_next;
    logic [7:0]     sum_reg, sum_next;
    logic           lead_reg, lead_next;

    // Result registers.
    logic           done_reg, done_next;
    status_t        status_reg, status_next;
    logic           reply_valid_reg, reply_valid_next;
    logic [7:0]     reply_byte_reg, reply_byte_next;
    logic [7:0]     read_data_reg, read_data_next;

    // Memory ports.
    logic              store_we;
    logic [AW-1:0]     store_waddr;
    logic [BYTE_W-1:0] store_wdata;
    logic [AW-1:0]     store_raddr;
    logic [BYTE_W-1:0] store_rdata;
    logic              stage_we;
    logic [PKT_IW-1:0] stage_waddr;
    logic [PKT_IW-1:0] stage_raddr;
    logic [BYTE_W-1:0] stage_rdata;

    // Intermediate values.
    logic           accept;
    logic           first_byte;
    logic           go_read, go_copy, go_fill, sweep_end, copy_end;
    logic [LW-1:0]  fill_len;
    logic [RW-1:0]  raddr_ext;
    logic [CAW-1:0] copy_addr;
    logic [CAW-1:0] wa_sum;
    logic [24:0]    count_sum;
    logic [23:0]    count_sat;
    logic [7:0]     pos_inc;
    kind_t          kind_b;
    logic [7:0]     block_b, sum_b;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign first_byte = (byte_pos_reg == 8'd0) && !lead_reg;
    assign raddr_ext  = RW'(read_addr);
    assign fill_len   = (LW'(cap_reg) < LW'(STORE_DEPTH)) ? LW'(cap_reg) : LW'(STORE_DEPTH);
    assign copy_end   = (copy_cnt_reg == 8'(PKT_LEN));
    assign copy_addr  = CAW'(write_addr_reg) + CAW'(copy_cnt_reg) - CAW'(1);
    assign wa_sum     = CAW'(write_addr_reg) + CAW'(PKT_LEN);
    assign count_sum  = {1'b0, rx_count_reg} + 25'(PKT_LEN);
    assign count_sat  = count_sum[24] ? COUNT_MAX : count_sum[23:0];
    assign pos_inc    = (byte_pos_reg == 8'hFF) ? byte_pos_reg : byte_pos_reg + 8'd1;
    assign sweep_end  = (state_reg == S_CLEAR) ? (sweep_reg == LW'(STORE_DEPTH - 1))
                                               : (sweep_reg == fill_len - LW'(1));

    // Store and staging memories.
    xcr_ram #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_waddr),
        .wr_data (store_wdata),
        .rd_addr (store_raddr),
        .rd_data (store_rdata)
    );

    xcr_ram #(.DEPTH(PKT_LEN), .AW(PKT_IW)) u_stage (
        .clk     (clk),
        .wr_en   (stage_we),
        .wr_addr (stage_waddr),
        .wr_data (rx_byte),
        .rd_addr (stage_raddr),
        .rd_data (stage_rdata)
    );

    // The incoming byte folded into the assembly state.
    always_comb
    begin
        kind_b  = kind_reg;
        block_b = block_reg;
        sum_b   = sum_reg;
        if (byte_pos_reg == 8'd0)
        begin
            if (rx_byte == BYTE_SOH)
            begin
                kind_b = KIND_SOH;
            end
            else if (rx_byte == BYTE_EOT)
            begin
                kind_b = KIND_EOT;
            end
            else
            begin
                kind_b = KIND_OTHER;
            end
        end
        else if (kind_reg == KIND_SOH)
        begin
            if (byte_pos_reg == 8'd1)
            begin
                block_b = rx_byte;
            end
            else if (byte_pos_reg == 8'd2)
            begin
                block_b = block_reg ^ rx_byte;
            end
            else if (byte_pos_reg < 8'(3 + PKT_LEN))
            begin
                sum_b = sum_reg + rx_byte;
            end
            else if (byte_pos_reg == 8'(3 + PKT_LEN))
            begin
                sum_b = sum_reg - rx_byte;
            end
        end
    end

    // Decisions taken when a command is accepted in idle.
    always_comb
    begin
        go_read = 1'b0;
        go_copy = 1'b0;
        go_fill = 1'b0;
        if (accept)
        begin
            unique case (mode)
                MODE_READ:   go_read = 1'b1;
                MODE_FILL:   go_fill = (fill_len != LW'(0));
                MODE_BYTE:   go_copy = last_of_buffer
                                       && !(first_byte && lead_skip_reg)
                                       && (kind_b == KIND_SOH)
                                       && (pos_inc >= 8'(FULL_LEN))
                                       && (block_b == BLOCK_CHECK)
                                       && (sum_b == 8'd0);
                MODE_PROMPT: go_read = 1'b0;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (go_read)
                begin
                    state_next = S_READ;
                end
                else if (go_copy)
                begin
                    state_next = S_COPY;
                end
                else if (go_fill)
                begin
                    state_next = S_FILL;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                if (copy_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FILL:
            begin
                if (sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Data path, memory ports and results.
    always_comb
    begin
        sweep_next       = sweep_reg;
        copy_cnt_next    = copy_cnt_reg;
        in_range_next    = in_range_reg;
        write_addr_next  = write_addr_reg;
        rx_count_next    = rx_count_reg;
        session_next     = session_reg;
        byte_pos_next    = byte_pos_reg;
        kind_next        = kind_reg;
        block_next       = block_reg;
        sum_next         = sum_reg;
        lead_next        = lead_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        reply_valid_next = reply_valid_reg;
        reply_byte_next  = reply_byte_reg;
        read_data_next   = read_data_reg;
        store_we         = 1'b0;
        store_waddr      = sweep_reg[AW-1:0];
        store_wdata      = BYTE_ERASED;
        store_raddr      = raddr_ext[AW-1:0];
        stage_we         = 1'b0;
        stage_waddr      = PKT_IW'(byte_pos_reg - 8'd3);
        stage_raddr      = copy_cnt_reg[PKT_IW-1:0];

        unique case (state_reg)
            // Sweep the whole store to the erased value after reset.
            S_CLEAR:
            begin
                store_we   = 1'b1;
                sweep_next = sweep_reg + LW'(1);
            end

            // Take one command.
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_PROMPT:
                        begin
                            done_next        = 1'b1;
                            status_next      = ST_PROMPT;
                            reply_valid_next = 1'b1;
                            reply_byte_next  = BYTE_NAK;
                            read_data_next   = 8'd0;
                        end
                        MODE_READ:
                        begin
                            in_range_next = (raddr_ext < RW'(STORE_DEPTH));
                        end
                        MODE_FILL:
                        begin
                            write_addr_next = '0;
                            sweep_next      = '0;
                        end
                        MODE_BYTE:
                        begin
                            if (first_byte && lead_skip_reg && last_of_buffer)
                            begin
                                // A one-byte buffer on the UART path is dropped.
                                byte_pos_next = '0;
                                kind_next     = KIND_NONE;
                                block_next    = '0;
                                sum_next      = '0;
                                lead_next     = 1'b0;
                            end
                            else if (first_byte && lead_skip_reg
                                     && rx_byte != BYTE_SOH && rx_byte != BYTE_EOT)
                            begin
                                lead_next = 1'b1;
                            end
                            else
                            begin
                                kind_next     = kind_b;
                                block_next    = block_b;
                                sum_next      = sum_b;
                                byte_pos_next = pos_inc;
                                stage_we      = (byte_pos_reg >= 8'd3)
                                                && (byte_pos_reg < 8'(3 + PKT_LEN))
                                                && (kind_reg == KIND_SOH);
                                if (last_of_buffer)
                                begin
                                    byte_pos_next = '0;
                                    kind_next     = KIND_NONE;
                                    block_next    = '0;
                                    sum_next      = '0;
                                    lead_next     = 1'b0;
                                    copy_cnt_next = '0;
                                    if (kind_b == KIND_EOT)
                                    begin
                                        session_next     = rx_count_reg;
                                        rx_count_next    = '0;
                                        write_addr_next  = '0;
                                        done_next        = 1'b1;
                                        status_next      = ST_EOT;
                                        reply_valid_next = 1'b1;
                                        reply_byte_next  = BYTE_ACK;
                                        read_data_next   = 8'd0;
                                    end
                                    else if (kind_b == KIND_SOH)
                                    begin
                                        if (!go_copy)
                                        begin
                                            done_next        = 1'b1;
                                            status_next      = ST_NAK;
                                            reply_valid_next = 1'b1;
                                            reply_byte_next  = BYTE_NAK;
                                            read_data_next   = 8'd0;
                                        end
                                    end
                                    else
                                    begin
                                        done_next        = 1'b1;
                                        status_next      = ST_UNREC;
                                        reply_valid_next = 1'b1;
                                        reply_byte_next  = BYTE_NAK;
                                        read_data_next   = 8'd0;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            // Registered store data is ready: deliver the readback word.
            S_READ:
            begin
                done_next        = 1'b1;
                status_next      = ST_READBACK;
                reply_valid_next = 1'b0;
                reply_byte_next  = 8'd0;
                read_data_next   = in_range_reg ? store_rdata : 8'd0;
            end

            // Copy staging to the store, one byte per cycle behind the read.
            S_COPY:
            begin
                copy_cnt_next = copy_cnt_reg + 8'd1;
                store_waddr   = copy_addr[AW-1:0];
                store_wdata   = stage_rdata;
                store_we      = (copy_cnt_reg != 8'd0) && (copy_addr < CAW'(STORE_DEPTH));
                if (copy_end)
                begin
                    write_addr_next  = (wa_sum > CAW'(STORE_DEPTH)) ? WAW'(STORE_DEPTH)
                                                                    : wa_sum[WAW-1:0];
                    rx_count_next    = count_sat;
                    done_next        = 1'b1;
                    reply_valid_next = 1'b1;
                    read_data_next   = 8'd0;
                    if (count_sat >= 24'(cap_reg))
                    begin
                        status_next     = ST_NAK;
                        reply_byte_next = BYTE_NAK;
                    end
                    else
                    begin
                        status_next     = ST_ACK;
                        reply_byte_next = BYTE_ACK;
                    end
                end
            end

            // Refill the destination area with the erased value.
            S_FILL:
            begin
                store_we   = 1'b1;
                sweep_next = sweep_reg + LW'(1);
            end

            default:
            begin
                store_we = 1'b0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= 15'd16384;
            lead_skip_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CAPACITY:  cap_reg       <= wr_data;
                REG_LEAD_SKIP: lead_skip_reg <= wr_data[0];
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            sweep_reg       <= '0;
            copy_cnt_reg    <= '0;
            in_range_reg    <= 1'b0;
            write_addr_reg  <= '0;
            rx_count_reg    <= '0;
            session_reg     <= '0;
            byte_pos_reg    <= '0;
            kind_reg        <= KIND_NONE;
            block_reg       <= '0;
            sum_reg         <= '0;
            lead_reg        <= 1'b0;
            done_reg        <= 1'b0;
            status_reg      <= ST_ACK;
            reply_valid_reg <= 1'b0;
            reply_byte_reg  <= '0;
            read_data_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            copy_cnt_reg    <= copy_cnt_next;
            in_range_reg    <= in_range_next;
            write_addr_reg  <= write_addr_next;
            rx_count_reg    <= rx_count_next;
            session_reg     <= session_next;
            byte_pos_reg    <= byte_pos_next;
            kind_reg        <= kind_next;
            block_reg       <= block_next;
            sum_reg         <= sum_next;
            lead_reg        <= lead_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            reply_valid_reg <= reply_valid_next;
            reply_byte_reg  <= reply_byte_next;
            read_data_reg   <= read_data_next;
        end
    end

    // Result ports.
    assign done          = done_reg;
    assign status        = status_reg;
    assign reply_valid   = reply_valid_reg;
    assign reply_byte    = reply_byte_reg;
    assign read_data     = read_data_reg;
    assign session_bytes = session_reg;

    // A readback word follows its command through S_READ into the result registers.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_READ) |=> ##1 (done_reg && status_reg == ST_READBACK))
        else $error("readback word not delivered on time");

    // The end of a packet copy always delivers a reply.
    a_copy_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY && copy_end) |=> (done_reg && reply_valid_reg))
        else $error("packet copy finished without a reply");

    // Store writes stay inside the store.
    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (WAW'(store_waddr) < WAW'(STORE_DEPTH)))
        else $error("store write outside the store");

    // The write pointer never passes the end of the store.
    a_wptr_sat: assert property (@(posedge clk) disable iff (!rst_n)
        write_addr_reg <= WAW'(STORE_DEPTH))
        else $error("write pointer past the store");

endmodule : xmodem_checksum_packet_receiver

`default_nettype wire

/* dv/tb_xmodem_checksum_packet_receiver.sv */
// ============================================================================
// tb_xmodem_checksum_packet_receiver
// Self-checking bench for the XMODEM checksum packet receiver. A scoreboard
// class predicts every reply from the accepted words and checks each done
// strobe against the oldest prediction. A short directed part comes first.
// A run of good packets back to back then writes the start of the store.
// Random phases follow, with different capacity and lead-skip settings and
// different amounts of sender idling.
// ============================================================================
`default_nettype none

module tb_xmodem_checksum_packet_receiver
    import xcr_pkg::*;
();

    localparam int DEPTH       = 16384;
    localparam int LIMIT       = 4_000_000;
    localparam int SETTLE      = 200;
    localparam int MAX_REPORTS = 10;

    // One predicted reply, field by field as on the result ports.
    typedef struct {
        status_t     status;
        logic        valid;
        logic [7:0]  reply;
        logic [7:0]  rdata;
        logic [23:0] sess;
    } reply_t;

    // Shapes of received buffers that the stimulus builds.
    typedef enum int {
        BUF_GOOD,
        BUF_BAD_HDR,
        BUF_BAD_SUM,
        BUF_SHORT,
        BUF_LONG,
        BUF_EOT,
        BUF_STRAY,
        BUF_ONE
    } buf_kind_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the receiver state and queues the expected replies.
    // ------------------------------------------------------------------------
    class xmodem_reply_board;
        int unsigned cap;
        logic        skip;
        logic [7:0]  mirror_store [DEPTH];
        logic [7:0]  staging [PKT_LEN];
        int unsigned wp;
        int unsigned rcv_count;
        int unsigned sess_count;
        int unsigned pos;
        kind_t       kind;
        logic [7:0]  blk;
        logic [7:0]  sum;
        logic        lead_dropped;
        reply_t      pending_replies [$];
        int          errors;

        function new();
            cap = DEPTH;
            skip = 1'b1;
            foreach (mirror_store[i])
                mirror_store[i] = BYTE_ERASED;
            foreach (staging[i])
                staging[i] = 8'h00;
            wp = 0;
            rcv_count = 0;
            sess_count = 0;
            errors = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            pos = 0;
            kind = KIND_NONE;
            blk = 8'h00;
            sum = 8'h00;
            lead_dropped = 1'b0;
        endfunction

        function void set_reg(logic idx, logic [14:0] val);
            if (idx == REG_CAPACITY)
                cap = val;
            else
                skip = val[0];
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void push_reply(status_t st, logic v, logic [7:0] rb, logic [7:0] rd);
            reply_t r;
            r.status = st;
            r.valid  = v;
            r.reply  = rb;
            r.rdata  = rd;
            r.sess   = sess_count[23:0];
            pending_replies.push_back(r);
        endfunction

        // Answer a closed SOH packet, copying it into the store first if it is complete.
        function void close_packet();
            if (pos < FULL_LEN || blk != BLOCK_CHECK || sum != 8'h00) begin
                push_reply(ST_NAK, 1'b1, BYTE_NAK, 8'h00);
                return;
            end
            for (int i = 0; i < PKT_LEN; i++)
                if (wp + i < DEPTH)
                    mirror_store[wp + i] = staging[i];
            wp = (wp + PKT_LEN > DEPTH) ? DEPTH : wp + PKT_LEN;
            rcv_count = (rcv_count + PKT_LEN > COUNT_MAX) ? COUNT_MAX : rcv_count + PKT_LEN;
            if (rcv_count >= cap)
                push_reply(ST_NAK, 1'b1, BYTE_NAK, 8'h00);
            else
                push_reply(ST_ACK, 1'b1, BYTE_ACK, 8'h00);
        endfunction

        // Note one accepted word and queue the reply that it causes, if any.
        function void take_word(logic [1:0] m, logic [7:0] b, logic lst, logic [13:0] ra);
            int unsigned n;
            if (m == MODE_PROMPT) begin
                push_reply(ST_PROMPT, 1'b1, BYTE_NAK, 8'h00);
                return;
            end
            if (m == MODE_READ) begin
                push_reply(ST_READBACK, 1'b0, 8'h00, mirror_store[ra]);
                return;
            end
            if (m == MODE_FILL) begin
                n = (cap > DEPTH) ? DEPTH : cap;
                for (int i = 0; i < n; i++)
                    mirror_store[i] = BYTE_ERASED;
                wp = 0;
                return;
            end

            // On the serial path a lone byte is ignored and one stray lead is dropped.
            if (pos == 0 && !lead_dropped && skip) begin
                if (lst) begin
                    clear_buffer();
                    return;
                end
                if (b != BYTE_SOH && b != BYTE_EOT) begin
                    lead_dropped = 1'b1;
                    return;
                end
            end

            if (pos == 0)
                kind = (b == BYTE_SOH) ? KIND_SOH : (b == BYTE_EOT) ? KIND_EOT : KIND_OTHER;
            else if (kind == KIND_SOH) begin
                if (pos == 1)
                    blk = b;
                else if (pos == 2)
                    blk = blk ^ b;
                else if (pos < 3 + PKT_LEN) begin
                    staging[pos - 3] = b;
                    sum = sum + b;
                end
                else if (pos == 3 + PKT_LEN)
                    sum = sum - b;
            end
            if (pos < 255)
                pos++;
            if (!lst)
                return;

            if (kind == KIND_EOT) begin
                sess_count = rcv_count;
                rcv_count = 0;
                wp = 0;
                push_reply(ST_EOT, 1'b1, BYTE_ACK, 8'h00);
            end
            else if (kind == KIND_SOH)
                close_packet();
            else
                push_reply(ST_UNREC, 1'b1, BYTE_NAK, 8'h00);
            clear_buffer();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endfunction

        // Check one strobed reply against the oldest prediction.
        function void match_reply(logic [2:0] st, logic v, logic [7:0] rb, logic [7:0] rd,
                                  logic [23:0] sb);
            reply_t want;
            if (pending_replies.size() == 0) begin
                note_error($sformatf("reply with nothing expected: status %0d byte %02h",
                                     st, rb));
                return;
            end
            want = pending_replies.pop_front();
            if (st !== want.status || v !== want.valid || rb !== want.reply ||
                rd !== want.rdata || sb !== want.sess)
                note_error($sformatf({"expected status %0d valid %0d byte %02h data %02h ",
                                      "session %0d, got status %0d valid %0d byte %02h ",
                                      "data %02h session %0d"},
                                     want.status, want.valid, want.reply, want.rdata,
                                     want.sess, st, v, rb, rd, sb));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        last_of_buffer = 1'b0;
    logic [13:0] read_addr = 14'h0000;
    logic        wr_en = 1'b0;
    logic        wr_index = REG_CAPACITY;
    logic [14:0] wr_data = 15'h0000;
    logic        done;
    logic [2:0]  status;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic [7:0]  read_data;
    logic [23:0] session_bytes;

    xmodem_reply_board board = new();
    int cycle_count = 0;
    int word_count = 0;
    int idle_pct = 0;
    int inject_pct = 0;

    xmodem_checksum_packet_receiver #(
        .STORE_DEPTH(DEPTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .rx_byte       (rx_byte),
        .last_of_buffer(last_of_buffer),
        .read_addr     (read_addr),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .done          (done),
        .status        (status),
        .reply_valid   (reply_valid),
        .reply_byte    (reply_byte),
        .read_data     (read_data),
        .session_bytes (session_bytes)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reply checking at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.match_reply(status, reply_valid, reply_byte, read_data, session_bytes);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == BYTE_SOH || b == BYTE_EOT);
        return b;
    endfunction

    // Drive one word, with an optional random gap, and hold it until accepted.
    task automatic send_word(logic [1:0] m, logic [7:0] b, logic lst, logic [13:0] ra,
                             bit counted);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge clk);
                start = 1'b0;
                mode = 2'($urandom);
                rx_byte = 8'($urandom);
                last_of_buffer = 1'($urandom);
                read_addr = 14'($urandom);
            end
        end
        @(negedge clk);
        start = 1'b1;
        mode = m;
        rx_byte = b;
        last_of_buffer = lst;
        read_addr = ra;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        board.take_word(m, b, lst, ra);
        if (counted)
            word_count++;
    endtask

    // Register write; only issued while the receiver is idle.
    task automatic write_reg(logic idx, logic [14:0] val);
        @(negedge clk);
        start = 1'b0;
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    // Hold off until every reply has come and the receiver has settled.
    task automatic wait_quiet();
        @(negedge clk);
        start = 1'b0;
        while (board.pending() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    // A prompt, a readback or, rarely, a refill.
    task automatic send_command();
        int pick;
        logic [13:0] ra;
        pick = $urandom_range(0, 99);
        ra = ($urandom_range(0, 99) < 60) ? 14'($urandom_range(0, 2047)) : 14'($urandom);
        if (pick < 45)
            send_word(MODE_PROMPT, 8'($urandom), 1'($urandom), 14'($urandom), 1'b1);
        else if (pick < 97)
            send_word(MODE_READ, 8'($urandom), 1'($urandom), ra, 1'b1);
        else
            send_word(MODE_FILL, 8'($urandom), 1'($urandom), 14'($urandom), 1'b1);
    endtask

    // Build one received buffer and send it byte by byte.
    task automatic send_buffer(buf_kind_t kind);
        logic [7:0] pkt [$];
        logic [7:0] blk;
        logic [7:0] csum;
        logic [7:0] d;
        int fill;
        int cut;
        pkt = {};
        case (kind)
            BUF_EOT:
            begin
                pkt.push_back(BYTE_EOT);
                repeat ($urandom_range(0, 3))
                    pkt.push_back(8'($urandom));
            end
            BUF_STRAY:
            begin
                pkt.push_back(stray_byte());
                pkt.push_back(stray_byte());
                repeat ($urandom_range(0, 3))
                    pkt.push_back(8'($urandom));
            end
            BUF_ONE:
            begin
                fill = $urandom_range(0, 3);
                pkt.push_back(fill == 0 ? BYTE_SOH : fill == 1 ? BYTE_EOT : 8'($urandom));
            end
            default:
            begin
                blk = 8'($urandom);
                csum = 8'h00;
                fill = $urandom_range(0, 9);
                pkt.push_back(BYTE_SOH);
                pkt.push_back(blk);
                if (kind == BUF_BAD_HDR)
                    pkt.push_back(~blk ^ (8'd1 << $urandom_range(0, 7)));
                else
                    pkt.push_back(~blk);
                for (int i = 0; i < PKT_LEN; i++) begin
                    d = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
                    csum = csum + d;
                    pkt.push_back(d);
                end
                if (kind == BUF_BAD_SUM)
                    pkt.push_back(csum + 8'($urandom_range(1, 255)));
                else
                    pkt.push_back(csum);
                if (kind == BUF_SHORT) begin
                    cut = $urandom_range(1, FULL_LEN - 1);
                    while (pkt.size() > cut)
                        void'(pkt.pop_back());
                end
                if (kind == BUF_LONG)
                    repeat ($urandom_range(1, 4))
                        pkt.push_back(8'($urandom));
            end
        endcase

        // A stray lead in front; dropped on the serial path, fatal otherwise.
        if (kind != BUF_ONE && kind != BUF_STRAY && $urandom_range(0, 99) < 25)
            send_word(MODE_BYTE, stray_byte(), 1'b0, 14'($urandom), !board.skip);

        for (int i = 0; i < pkt.size(); i++) begin
            if ($urandom_range(0, 99) < inject_pct)
                send_command();
            send_word(MODE_BYTE, pkt[i], i == pkt.size() - 1, 14'($urandom),
                      !(kind == BUF_ONE && board.skip));
        end
    endtask

    // One random phase under a given register setting and sender idling.
    task automatic run_phase(logic [14:0] cap, logic skip, int idle, int n_words);
        int target;
        int pick;
        wait_quiet();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_LEAD_SKIP, {14'h0000, skip});
        idle_pct = idle;
        inject_pct = 1;
        target = word_count + n_words;
        while (word_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
                send_buffer(BUF_GOOD);
            else if (pick < 33)
                send_buffer(BUF_BAD_HDR);
            else if (pick < 38)
                send_buffer(BUF_BAD_SUM);
            else if (pick < 46)
                send_buffer(BUF_SHORT);
            else if (pick < 50)
                send_buffer(BUF_LONG);
            else if (pick < 58)
                send_buffer(BUF_EOT);
            else if (pick < 64)
                send_buffer(BUF_STRAY);
            else if (pick < 70)
                send_buffer(BUF_ONE);
            else
                send_command();
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        // Wait out the store sweep, then set the capacity to the store depth and the serial path.
        wait_quiet();
        write_reg(REG_CAPACITY, 15'd16384);
        write_reg(REG_LEAD_SKIP, 15'd1);

        // Directed: prompt and readback at both address extremes.
        send_word(MODE_PROMPT, 8'hFF, 1'b1, 14'h3FFF, 1'b1);
        send_word(MODE_READ, 8'h00, 1'b0, 14'h0000, 1'b1);
        send_word(MODE_READ, 8'hFF, 1'b1, 14'h3FFF, 1'b1);
        // A one-byte buffer is ignored on the serial path.
        send_word(MODE_BYTE, BYTE_SOH, 1'b1, 14'h0000, 1'b0);
        // Dropped lead, then a short SOH buffer.
        send_word(MODE_BYTE, 8'hFF, 1'b0, 14'h0000, 1'b0);
        send_word(MODE_BYTE, BYTE_SOH, 1'b0, 14'h0000, 1'b1);
        send_word(MODE_BYTE, 8'h00, 1'b1, 14'h0000, 1'b1);
        // A second stray lead makes the buffer unrecognized.
        send_word(MODE_BYTE, 8'h55, 1'b0, 14'h0000, 1'b0);
        send_word(MODE_BYTE, 8'hAA, 1'b1, 14'h0000, 1'b1);
        // EOT with trailing bytes.
        send_word(MODE_BYTE, BYTE_EOT, 1'b0, 14'h0000, 1'b1);
        send_word(MODE_BYTE, 8'h00, 1'b0, 14'h0000, 1'b1);
        send_word(MODE_BYTE, 8'hFF, 1'b1, 14'h0000, 1'b1);
        // Commands in the middle of a buffer leave it in place.
        send_word(MODE_BYTE, BYTE_SOH, 1'b0, 14'h0000, 1'b1);
        send_word(MODE_PROMPT, 8'h00, 1'b0, 14'h2AAA, 1'b1);
        send_word(MODE_READ, 8'h00, 1'b0, 14'h1555, 1'b1);
        send_word(MODE_BYTE, 8'h10, 1'b1, 14'h0000, 1'b1);
        // Refill of the whole area.
        send_word(MODE_FILL, 8'hFF, 1'b1, 14'h3FFF, 1'b1);

        // Four good packets back to back, then read the start of the store.
        wait_quiet();
        idle_pct = 0;
        inject_pct = 0;
        repeat (4)
            send_buffer(BUF_GOOD);
        repeat (8)
            send_word(MODE_READ, 8'h00, 1'b0, 14'($urandom_range(0, 4 * PKT_LEN - 1)), 1'b1);
        send_buffer(BUF_EOT);
        send_word(MODE_PROMPT, 8'h00, 1'b0, 14'h0000, 1'b1);

        // Random phases: no idling, heavy idling, light idling, then none.
        run_phase(15'd0, 1'b0, 0, 375);
        run_phase(15'd16383, 1'b1, 64, 375);
        run_phase(15'($urandom_range(1, 4095)), 1'b0, 29, 375);
        run_phase(15'd128, 1'b1, 0, 375);

        wait_quiet();
        if (board.errors == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule : tb_xmodem_checksum_packet_receiver

`default_nettype wire
